### hdl/niche_tournament_selector_defines.svh
// assertion macros for the niche tournament selector
// used by nts_ctrl and nts_datapath, which must have clk and arst_n in scope
`ifndef NICHE_TOURNAMENT_SELECTOR_DEFINES_SVH
`define NICHE_TOURNAMENT_SELECTOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NTS_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("nts: same-cycle check failed");

// next-cycle implication, disabled during reset
`define NTS_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("nts: next-cycle check failed");

`endif

### hdl/nts_pkg.sv
// shared constants, codes and controller/datapath command types
// for the niche tournament selector; no dependencies
package nts_pkg;

	localparam int NICHES    = 64;
	localparam int POOL_SIZE = 4096;

	localparam int ACT_W   = 2;
	localparam int POS_W   = 12;
	localparam int ID_W    = 6;
	localparam int NICHE_W = $clog2(NICHES);
	localparam int POOL_W  = $clog2(POOL_SIZE);
	localparam int PTR_W   = $clog2(POOL_SIZE + 1);
	localparam int COUNT_W = 13;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD   = 2'd0,
		ACT_SWAP   = 2'd1,
		ACT_SELECT = 2'd2,
		ACT_COMMIT = 2'd3
	} act_t;

	typedef struct packed {
		logic accept;
		logic commit;
		logic rd_pool;
		logic cnt_rd;
		logic cmp;
		logic swap_wa;
		logic swap_wb;
		logic tally_wr;
		logic copy;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic copy_last;
	} sts_t;

endpackage

### hdl/nts_op_if.sv
// operation channel: valid/ready handshake and the input item fields
// depends on nts_pkg
interface nts_op_if import nts_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [POS_W-1:0] first_pos;
	logic [POS_W-1:0] second_pos;
	logic [ID_W-1:0]  niche;

	modport source (output valid, action, first_pos, second_pos, niche, input ready);
	modport sink   (input valid, action, first_pos, second_pos, niche, output ready);

endinterface

### hdl/nts_res_if.sv
// result channel: valid/ready handshake and the result item fields
// depends on nts_pkg
interface nts_res_if import nts_pkg::*; ();

	logic            valid;
	logic            ready;
	logic [ID_W-1:0] winner;
	logic            status;

	modport source (output valid, winner, status, input ready);
	modport sink   (input valid, winner, status, output ready);

endinterface

### hdl/nts_ctrl.sv
// controller state machine: sequences load, swap, select and commit sweep
// depends on nts_pkg and niche_tournament_selector_defines.svh
`include "niche_tournament_selector_defines.svh"

module nts_ctrl import nts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ACT_W-1:0] action,
	output logic             out_valid,
	input  logic             out_ready,
	output cmd_t             cmd,
	input  sts_t             sts
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_RD   = 10'b00_0000_0010,
		ST_SWA  = 10'b00_0000_0100,
		ST_SWB  = 10'b00_0000_1000,
		ST_CNT  = 10'b00_0001_0000,
		ST_CMP  = 10'b00_0010_0000,
		ST_TRD  = 10'b00_0100_0000,
		ST_TWR  = 10'b00_1000_0000,
		ST_COPY = 10'b01_0000_0000,
		ST_DONE = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	act_t   action_q;
	logic   out_valid_q;
	logic   slot_free;
	act_t   act_in;

	assign act_in    = act_t'(action);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (act_in)
						ACT_LOAD:   state_d = ST_TRD;
						ACT_SWAP:   state_d = ST_RD;
						ACT_SELECT: state_d = ST_RD;
						ACT_COMMIT: begin
							cmd.commit = 1'b1;
							state_d    = ST_COPY;
						end
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD: begin
				cmd.rd_pool = 1'b1;
				state_d     = (action_q == ACT_SWAP) ? ST_SWA : ST_CNT;
			end
			ST_SWA: begin
				cmd.swap_wa = 1'b1;
				state_d     = ST_SWB;
			end
			ST_SWB: begin
				cmd.swap_wb = 1'b1;
				state_d     = ST_DONE;
			end
			ST_CNT: begin
				cmd.cnt_rd = 1'b1;
				state_d    = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = ST_TRD;
			end
			ST_TRD: begin
				state_d = ST_TWR;
			end
			ST_TWR: begin
				cmd.tally_wr = 1'b1;
				state_d      = ST_DONE;
			end
			ST_COPY: begin
				cmd.copy = 1'b1;
				if (sts.copy_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			action_q    <= ACT_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				action_q <= act_in;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`NTS_ASSERT_IMP(a_swb_after_swa, state_q == ST_SWB, $past(state_q) == ST_SWA)
	`NTS_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, !in_ready)
	`NTS_ASSERT_NXT(a_done_waits_slot, state_q == ST_DONE && out_valid_q && !out_ready,
		state_q == ST_DONE)

endmodule

### hdl/nts_datapath.sv
// datapath: old and new pool memories, double-banked count/tally memories,
// append pointer, commit sweep index and result register; depends on nts_pkg
`include "niche_tournament_selector_defines.svh"

module nts_datapath import nts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [POS_W-1:0] first_pos,
	input  logic [POS_W-1:0] second_pos,
	input  logic [ID_W-1:0]  niche,
	output logic [ID_W-1:0]  winner,
	output logic             status
);

	logic [NICHE_W-1:0] old_mem [POOL_SIZE];
	logic [NICHE_W-1:0] new_mem [POOL_SIZE];
	logic [COUNT_W-1:0] cmem [2][NICHES];

	logic [POOL_W-1:0]  pa_s1, pb_s1;
	logic [NICHE_W-1:0] ea_q, eb_q, app_id_q, win_q, new_rd_q;
	logic               stat_q;
	logic [ID_W-1:0]    winner_q;
	logic               status_q;

	logic [PTR_W-1:0]   ptr_q;
	logic [POOL_W-1:0]  idx_q;
	logic [POOL_W-1:0]  copy_addr_s1;
	logic               copy_wr_s1;
	logic               sel_q;
	logic [NICHES-1:0]  vld_q [2];

	logic [COUNT_W-1:0] rd0_q [2];
	logic [COUNT_W-1:0] rd1_q [2];
	logic [1:0]         vrd0_q, vrd1_q;

	logic               full;
	logic               app_we;
	logic               old_we;
	logic [POOL_W-1:0]  old_wa;
	logic [NICHE_W-1:0] old_wd;
	logic [NICHE_W-1:0] addr0;
	logic [COUNT_W-1:0] cnt_a, cnt_b, tally_cur, tally_inc;
	logic [NICHE_W-1:0] win_nxt;
	logic               tb;

	assign full    = (ptr_q == PTR_W'(POOL_SIZE));
	assign app_we  = cmd.tally_wr && !full;
	assign tb      = ~sel_q;
	assign addr0   = cmd.cnt_rd ? ea_q : app_id_q;

	assign cnt_a     = vrd0_q[sel_q] ? rd0_q[sel_q] : '0;
	assign cnt_b     = vrd1_q[sel_q] ? rd1_q[sel_q] : '0;
	assign tally_cur = vrd0_q[tb] ? rd0_q[tb] : '0;
	assign tally_inc = (tally_cur == COUNT_MAX) ? tally_cur : tally_cur + 1'b1;
	assign win_nxt   = (cnt_a > cnt_b) ? eb_q : ea_q;

	assign old_we = copy_wr_s1 || cmd.swap_wa || cmd.swap_wb;
	assign old_wa = copy_wr_s1 ? copy_addr_s1 : (cmd.swap_wa ? pa_s1 : pb_s1);
	assign old_wd = copy_wr_s1 ? new_rd_q : (cmd.swap_wa ? eb_q : ea_q);

	assign sts.copy_last = (idx_q == POOL_W'(POOL_SIZE - 1));
	assign winner        = winner_q;
	assign status        = status_q;

	// pool memories
	always_ff @(posedge clk) begin
		if (old_we) begin
			old_mem[old_wa] <= old_wd;
		end
		if (cmd.rd_pool) begin
			ea_q <= old_mem[pa_s1];
			eb_q <= old_mem[pb_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (app_we) begin
			new_mem[ptr_q[POOL_W-1:0]] <= app_id_q;
		end
		new_rd_q <= new_mem[idx_q];
	end

	// count and tally banks, roles swap on commit
	for (genvar b = 0; b < 2; b++) begin : g_bank
		always_ff @(posedge clk) begin
			if (app_we && (tb == 1'(b))) begin
				cmem[b][app_id_q] <= tally_inc;
			end
			rd0_q[b]  <= cmem[b][addr0];
			rd1_q[b]  <= cmem[b][eb_q];
			vrd0_q[b] <= vld_q[b][addr0];
			vrd1_q[b] <= vld_q[b][eb_q];
		end
	end

	// item payload and result register
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pa_s1    <= first_pos[POOL_W-1:0];
			pb_s1    <= second_pos[POOL_W-1:0];
			app_id_q <= niche[NICHE_W-1:0];
			win_q    <= '0;
			stat_q   <= 1'b0;
		end
		if (cmd.cmp) begin
			app_id_q <= win_nxt;
			win_q    <= win_nxt;
		end
		if (cmd.tally_wr) begin
			stat_q <= full;
		end
		if (cmd.out_load) begin
			winner_q <= ID_W'(win_q);
			status_q <= stat_q;
		end
		copy_addr_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			idx_q      <= '0;
			sel_q      <= 1'b0;
			copy_wr_s1 <= 1'b0;
			vld_q[0]   <= '0;
			vld_q[1]   <= '0;
		end else begin
			copy_wr_s1 <= cmd.copy;
			if (cmd.commit) begin
				ptr_q        <= '0;
				idx_q        <= '0;
				sel_q        <= ~sel_q;
				vld_q[sel_q] <= '0;
			end else begin
				if (app_we) begin
					ptr_q              <= ptr_q + 1'b1;
					vld_q[tb][app_id_q] <= 1'b1;
				end
				if (cmd.copy) begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	`NTS_ASSERT_NXT(a_full_holds_ptr, cmd.tally_wr && full, $stable(ptr_q))
	`NTS_ASSERT_IMP(a_copy_write_follows_read, copy_wr_s1, $past(cmd.copy))
	`NTS_ASSERT_IMP(a_ptr_bound, cmd.tally_wr, ptr_q <= PTR_W'(POOL_SIZE))

endmodule

### hdl/niche_tournament_selector.sv
// top level of the niche tournament selector: controller plus datapath
// depends on nts_pkg, nts_op_if, nts_res_if, nts_ctrl, nts_datapath
//
//  channel  | dir | fields                                  | handshake
//  ---------+-----+-----------------------------------------+-----------
//  op       | in  | action, first_pos, second_pos, niche    | valid/ready
//  result   | out | winner, status                          | valid/ready
//
// one item at a time; swap and select use registered reads of the
// pool and count memories, and swap writes through the single write
// port of the old pool; commit copies the new pool into the old pool
// one entry per cycle, while count and tally banks swap at once
// a new item is taken while the previous result still waits in the output
// register; a stalled result holds the block in its final state
// asynchronous active-low reset clears control state and count valid bits
module niche_tournament_selector import nts_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	nts_op_if.sink     op,
	nts_res_if.source  result
);

	cmd_t cmd;
	sts_t sts;

	nts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (op.valid),
		.in_ready  (op.ready),
		.action    (op.action),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	nts_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.first_pos  (op.first_pos),
		.second_pos (op.second_pos),
		.niche      (op.niche),
		.winner     (result.winner),
		.status     (result.status)
	);

endmodule
